>>> hdl/mqlb_pkg.sv
// Shared types and constants for the multi-queue linked buffer.
package mqlb_pkg;

  // Fixed field widths of the stream payload
  localparam int KEY_W    = 32;
  localparam int QIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int IN_USER_W = 1 + QIDX_W;

  // Command carried in tuser
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // Result status carried in tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADQ  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Node memory strobes
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic next_we;
  } ram_ctl_t;

endpackage

>>> hdl/mqlb_node_ram.sv
// Node pool storage: key and next-pointer memories, one read and one write port each.
module mqlb_node_ram #(
  parameter int NODES = 64,
  parameter int AW    = 6
) (
  input  logic                   clk_i,
  input  mqlb_pkg::ram_ctl_t     ctl_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic [AW-1:0]          key_addr_i,
  input  logic [mqlb_pkg::KEY_W-1:0] key_data_i,
  input  logic [AW-1:0]          next_addr_i,
  input  logic [AW-1:0]          next_data_i,
  output logic [mqlb_pkg::KEY_W-1:0] rd_key_o,
  output logic [AW-1:0]          rd_next_o
);
  import mqlb_pkg::*;

  logic [KEY_W-1:0] key_mem [NODES];
  logic [AW-1:0]    next_mem [NODES];

  // key memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[key_addr_i] <= key_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_key_o <= key_mem[rd_addr_i];
    end
  end

  // next-pointer memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.next_we) begin
      next_mem[next_addr_i] <= next_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_next_o <= next_mem[rd_addr_i];
    end
  end

endmodule

>>> hdl/multi_queue_linked_buffer.sv
// Multi-queue linked buffer: QUEUES FIFO queues sharing one pool of NODES linked nodes.
// Each input transfer is an enqueue or a dequeue naming a queue; each gives exactly one
// result transfer (key_out, status). In the accept state (S_IDLE) the node memory is
// read (free-list head for an enqueue, queue head for a dequeue); in the execute state
// (S_EXEC) the read data is used, the node memory and queue pointers are written and
// the result is loaded into the output register. A new item is taken while a result
// waits in the output register; the block holds in its execute state only if the
// previous result is still untaken. No clearing pass is needed after reset.
module multi_queue_linked_buffer #(
  parameter int QUEUES = 10,
  parameter int NODES  = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mqlb_pkg::KEY_W-1:0]         s_axis_tdata,  // [31:0] key_in
  input  logic [mqlb_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [0] cmd, [4:1] queue_index
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mqlb_pkg::KEY_W-1:0]         m_axis_tdata,  // [31:0] key_out
  output logic [mqlb_pkg::STATUS_W-1:0]      m_axis_tuser   // [1:0] status
);
  import mqlb_pkg::*;

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW  = $clog2(NODES + 1);
  localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  // sequencer and latched item
  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [QIDX_W-1:0] q_q;
  logic              qok_q;
  logic [KEY_W-1:0]  key_q;

  // queue table
  logic [NW-1:0] head_q [QUEUES];
  logic [NW-1:0] tail_q [QUEUES];
  logic [QUEUES-1:0] nonempty_q;

  // pool bookkeeping
  logic [NW-1:0] free_head_q;
  logic [CW-1:0] free_count_q;
  logic [CW-1:0] fresh_mark_q;

  // output register
  logic             out_valid_q;
  logic [KEY_W-1:0] out_key_q;
  status_e          out_status_q;

  // node memory hookup
  ram_ctl_t         ram_ctl;
  logic [NW-1:0]    rd_addr;
  logic [NW-1:0]    key_waddr;
  logic [NW-1:0]    next_waddr;
  logic [NW-1:0]    next_wdata;
  logic [KEY_W-1:0] rd_key;
  logic [NW-1:0]    rd_next;

  // input decode
  logic              accept;
  cmd_e              in_cmd;
  logic [QIDX_W-1:0] in_q;
  logic              in_qok;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_cmd = cmd_e'(s_axis_tuser[0]);
  assign in_q   = s_axis_tuser[QIDX_W:1];
  assign in_qok = ({1'b0, in_q} < (QIDX_W + 1)'(QUEUES));

  assign s_axis_tready = (state_q == S_IDLE);

  // read address: queue head for a dequeue, free-list head otherwise
  always_comb begin
    if (in_cmd == CMD_DEQ && in_qok) begin
      rd_addr = head_q[in_q[QIW-1:0]];
    end else begin
      rd_addr = free_head_q;
    end
  end

  // execute stage
  logic [QIW-1:0]  qi;
  logic            fire;
  status_e         res_status;
  logic [KEY_W-1:0] res_key;
  logic [NW-1:0]   alloc_node;
  logic [NW-1:0]   deq_node;
  logic            use_free;
  logic            q_set_head, q_set_tail, q_ne_we, q_ne_val;
  logic [NW-1:0]   q_head_val;
  logic            pool_pop_free, pool_pop_fresh, pool_push;

  assign qi       = q_q[QIW-1:0];
  assign fire     = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign deq_node = head_q[qi];
  assign use_free = (free_count_q != '0);

  always_comb begin
    res_status     = ST_OK;
    res_key        = '0;
    alloc_node     = free_head_q;
    q_set_head     = 1'b0;
    q_set_tail     = 1'b0;
    q_ne_we        = 1'b0;
    q_ne_val       = 1'b0;
    q_head_val     = rd_next;
    pool_pop_free  = 1'b0;
    pool_pop_fresh = 1'b0;
    pool_push      = 1'b0;
    ram_ctl        = '0;
    key_waddr      = free_head_q;
    next_waddr     = free_head_q;
    next_wdata     = free_head_q;
    ram_ctl.rd_en  = accept;

    if (!qok_q) begin
      res_status = ST_BADQ;
    end else if (cmd_q == CMD_ENQ) begin
      // pick a node: recycled list first, then the fresh watermark
      if (use_free) begin
        alloc_node    = free_head_q;
        pool_pop_free = 1'b1;
      end else if (fresh_mark_q < CW'(NODES)) begin
        alloc_node     = fresh_mark_q[NW-1:0];
        pool_pop_fresh = 1'b1;
      end else begin
        res_status = ST_FULL;
      end
      if (res_status == ST_OK) begin
        ram_ctl.key_we = 1'b1;
        key_waddr      = alloc_node;
        q_set_tail     = 1'b1;
        if (nonempty_q[qi]) begin
          // link behind the current tail
          ram_ctl.next_we = 1'b1;
          next_waddr      = tail_q[qi];
          next_wdata      = alloc_node;
        end else begin
          q_set_head = 1'b1;
          q_head_val = alloc_node;
          q_ne_we    = 1'b1;
          q_ne_val   = 1'b1;
        end
      end
    end else begin
      if (!nonempty_q[qi]) begin
        res_status = ST_EMPTY;
      end else begin
        res_key = rd_key;
        if (deq_node == tail_q[qi]) begin
          q_ne_we = 1'b1;
        end else begin
          q_set_head = 1'b1;
          q_head_val = rd_next;
        end
        // push the node onto the recycled list
        ram_ctl.next_we = 1'b1;
        next_waddr      = deq_node;
        next_wdata      = free_head_q;
        pool_push       = 1'b1;
      end
    end

    if (!fire) begin
      ram_ctl.key_we  = 1'b0;
      ram_ctl.next_we = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_cmd;
      q_q   <= in_q;
      qok_q <= in_qok;
      key_q <= s_axis_tdata;
    end
  end

  // queue pointers (no reset, guarded by nonempty)
  always_ff @(posedge clk_i) begin
    if (fire && q_set_head) begin
      head_q[qi] <= q_head_val;
    end
    if (fire && q_set_tail) begin
      tail_q[qi] <= alloc_node;
    end
  end

  // queue occupancy and pool bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q   <= '0;
      free_head_q  <= '0;
      free_count_q <= '0;
      fresh_mark_q <= '0;
    end else if (fire) begin
      if (q_ne_we) begin
        nonempty_q[qi] <= q_ne_val;
      end
      if (pool_pop_free) begin
        free_head_q  <= rd_next;
        free_count_q <= free_count_q - 1'b1;
      end
      if (pool_pop_fresh) begin
        fresh_mark_q <= fresh_mark_q + 1'b1;
      end
      if (pool_push) begin
        free_head_q  <= deq_node;
        free_count_q <= free_count_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_key_q    <= res_key;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_key_q;
  assign m_axis_tuser  = out_status_q;

  mqlb_node_ram #(
    .NODES(NODES),
    .AW   (NW)
  ) u_node_ram (
    .clk_i      (clk_i),
    .ctl_i      (ram_ctl),
    .rd_addr_i  (rd_addr),
    .key_addr_i (key_waddr),
    .key_data_i (key_q),
    .next_addr_i(next_waddr),
    .next_data_i(next_wdata),
    .rd_key_o   (rd_key),
    .rd_next_o  (rd_next)
  );

  // the recycled list never holds more nodes than were ever handed out
  assert property (@(posedge clk_i) disable iff (!rst_ni) free_count_q <= fresh_mark_q)
    else $error("free list larger than allocated nodes");

  // the watermark never passes the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni) fresh_mark_q <= CW'(NODES))
    else $error("fresh watermark beyond pool");

  // no input is taken while an item is still in its execute state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !accept)
    else $error("input accepted during execute");

  // a result is loaded only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !fire)
    else $error("result overwrote a pending transfer");

endmodule
